// ----- design/etl_pkg.sv -----
// Shared types, token codes and character-class helpers for the expression token lexer.
// No dependencies; every other design file refers to this package by scoped names.
`default_nettype none

package etl_pkg;

    localparam int VALUE_W = 64;
    localparam logic [7:0] MAX_IDENT_LEN = 8'd128;

    // token queue between the front and back parts
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = QAW + 1;

    // token kinds
    localparam logic [5:0] K_END     = 6'd0;
    localparam logic [5:0] K_COMMA   = 6'd1;
    localparam logic [5:0] K_AT      = 6'd2;
    localparam logic [5:0] K_LPAR    = 6'd3;
    localparam logic [5:0] K_RPAR    = 6'd4;
    localparam logic [5:0] K_LBRK    = 6'd5;
    localparam logic [5:0] K_RBRK    = 6'd6;
    localparam logic [5:0] K_QUEST   = 6'd7;
    localparam logic [5:0] K_COLON   = 6'd8;
    localparam logic [5:0] K_PLUS    = 6'd9;
    localparam logic [5:0] K_MINUS   = 6'd10;
    localparam logic [5:0] K_STAR    = 6'd11;
    localparam logic [5:0] K_SLASH   = 6'd12;
    localparam logic [5:0] K_PERCENT = 6'd13;
    localparam logic [5:0] K_CARET   = 6'd14;
    localparam logic [5:0] K_TILDE   = 6'd15;
    localparam logic [5:0] K_LAND    = 6'd16;
    localparam logic [5:0] K_AMP     = 6'd17;
    localparam logic [5:0] K_LOR     = 6'd18;
    localparam logic [5:0] K_BAR     = 6'd19;
    localparam logic [5:0] K_EQEQ    = 6'd20;
    localparam logic [5:0] K_ASSIGN  = 6'd21;
    localparam logic [5:0] K_NE      = 6'd22;
    localparam logic [5:0] K_NOT     = 6'd23;
    localparam logic [5:0] K_LE      = 6'd24;
    localparam logic [5:0] K_SHL     = 6'd25;
    localparam logic [5:0] K_LT      = 6'd26;
    localparam logic [5:0] K_GE      = 6'd27;
    localparam logic [5:0] K_SHR     = 6'd28;
    localparam logic [5:0] K_GT      = 6'd29;
    localparam logic [5:0] K_DOLLAR  = 6'd30;
    localparam logic [5:0] K_HASH    = 6'd31;
    localparam logic [5:0] K_NUMBER  = 6'd32;
    localparam logic [5:0] K_IDENT   = 6'd33;
    localparam logic [5:0] K_ICHAR   = 6'd34;
    localparam logic [5:0] K_ERROR   = 6'd35;

    // error codes
    localparam logic [2:0] E_UNEXP = 3'd0;
    localparam logic [2:0] E_HEX   = 3'd1;
    localparam logic [2:0] E_BIN   = 3'd2;
    localparam logic [2:0] E_OCT   = 3'd3;
    localparam logic [2:0] E_DEC   = 3'd4;
    localparam logic [2:0] E_LZERO = 3'd5;
    localparam logic [2:0] E_LONG  = 3'd6;

    localparam logic [7:0] CH_APOS = 8'h27;

    typedef struct packed {
        logic [5:0]         kind;
        logic [VALUE_W-1:0] value;
        logic [7:0]         ichar;
        logic [7:0]         ilen;
        logic [2:0]         err;
    } t_tok;

    // all tokens caused by one request: one, or two when a held token is flushed or an apostrophe closes an identifier
    typedef struct packed {
        logic           two;
        t_tok [1:0]     res;
    } t_rec;

    function automatic logic is_dig(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return is_dig(c) || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
    endfunction

    function automatic logic is_identch(input logic [7:0] c);
        return is_letter(c) || is_dig(c) || (c == "_") || (c == ".");
    endfunction

    function automatic logic [3:0] digit_val(input logic [7:0] c);
        logic [7:0] d;
        d = 8'd0;
        if (is_dig(c)) begin
            d = c - 8'h30;
        end else if ((c >= "a") && (c <= "f")) begin
            d = c - 8'h61 + 8'd10;
        end else if ((c >= "A") && (c <= "F")) begin
            d = c - 8'h41 + 8'd10;
        end
        return d[3:0];
    endfunction

    function automatic t_tok mk_tok(input logic [5:0] kind, input logic [VALUE_W-1:0] value,
                                    input logic [7:0] ichar, input logic [7:0] ilen,
                                    input logic [2:0] err);
        t_tok t;
        t.kind  = kind;
        t.value = value;
        t.ichar = ichar;
        t.ilen  = ilen;
        t.err   = err;
        return t;
    endfunction

endpackage

`default_nettype wire

// ----- design/etl_front.sv -----
// Front part of the expression token lexer: scan state machine and number accumulator.
// Classifies each accepted byte and pushes its tokens as one record. Uses etl_pkg.
`default_nettype none

module etl_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_accept,
    input  wire logic [7:0]    i_ch,
    output logic               o_push,
    output etl_pkg::t_rec      o_rec
);

    localparam logic [4:0] M_IDLE   = 5'd0;
    localparam logic [4:0] M_AMP    = 5'd1;
    localparam logic [4:0] M_BAR    = 5'd2;
    localparam logic [4:0] M_EQ     = 5'd3;
    localparam logic [4:0] M_EXCL   = 5'd4;
    localparam logic [4:0] M_LT     = 5'd5;
    localparam logic [4:0] M_GT     = 5'd6;
    localparam logic [4:0] M_DOLLAR = 5'd7;
    localparam logic [4:0] M_HASH   = 5'd8;
    localparam logic [4:0] M_ZERO   = 5'd9;
    localparam logic [4:0] M_HEXS   = 5'd10;
    localparam logic [4:0] M_BINS   = 5'd11;
    localparam logic [4:0] M_OCTS   = 5'd12;
    localparam logic [4:0] M_HEX    = 5'd13;
    localparam logic [4:0] M_BIN    = 5'd14;
    localparam logic [4:0] M_OCT    = 5'd15;
    localparam logic [4:0] M_DEC    = 5'd16;
    localparam logic [4:0] M_IDENT  = 5'd17;
    localparam logic [4:0] M_DRAIN  = 5'd18;

    localparam int VW = etl_pkg::VALUE_W;

    logic [4:0]    r_mode, n_mode;
    logic [VW-1:0] r_acc,  n_acc;
    logic [7:0]    r_cnt,  n_cnt;

    etl_pkg::t_tok [1:0] w_res;
    logic [1:0]          w_nres;
    logic                w_again;
    logic                w_err;
    logic [2:0]          w_err_code;
    logic [3:0]          w_dv;
    logic                w_ok;
    logic [VW-1:0]       w_scaled;
    logic [VW-1:0]       w_mac;
    etl_pkg::t_tok       w_zero_tok;

    function automatic logic [5:0] punct_kind(input logic [7:0] c);
        logic [5:0] k;
        unique case (c)
            ",":     k = etl_pkg::K_COMMA;
            "@":     k = etl_pkg::K_AT;
            "(":     k = etl_pkg::K_LPAR;
            ")":     k = etl_pkg::K_RPAR;
            "[":     k = etl_pkg::K_LBRK;
            "]":     k = etl_pkg::K_RBRK;
            "?":     k = etl_pkg::K_QUEST;
            ":":     k = etl_pkg::K_COLON;
            "+":     k = etl_pkg::K_PLUS;
            "-":     k = etl_pkg::K_MINUS;
            "*":     k = etl_pkg::K_STAR;
            "/":     k = etl_pkg::K_SLASH;
            "%":     k = etl_pkg::K_PERCENT;
            "^":     k = etl_pkg::K_CARET;
            default: k = etl_pkg::K_TILDE;
        endcase
        return k;
    endfunction

    assign w_dv       = etl_pkg::digit_val(i_ch);
    assign w_zero_tok = etl_pkg::mk_tok(etl_pkg::K_END, '0, 8'd0, 8'd0, 3'd0);

    // digit accepted in the base of the current number mode
    always_comb begin
        unique case (r_mode)
            M_HEX, M_HEXS, M_DOLLAR, M_HASH: w_ok = etl_pkg::is_hex(i_ch);
            M_BIN, M_BINS:                   w_ok = etl_pkg::is_dig(i_ch) && (w_dv < 4'd2);
            M_OCT, M_OCTS:                   w_ok = etl_pkg::is_dig(i_ch) && (w_dv < 4'd8);
            default:                         w_ok = etl_pkg::is_dig(i_ch);
        endcase
    end

    // acc * base + digit with shifts only
    always_comb begin
        unique case (r_mode)
            M_HEX:   w_scaled = r_acc << 4;
            M_BIN:   w_scaled = r_acc << 1;
            M_OCT:   w_scaled = r_acc << 3;
            default: w_scaled = (r_acc << 3) + (r_acc << 1);
        endcase
        w_mac = w_scaled + {{(VW-4){1'b0}}, w_dv};
    end

    always_comb begin
        n_mode     = r_mode;
        n_acc      = r_acc;
        n_cnt      = r_cnt;
        w_res[0]   = w_zero_tok;
        w_res[1]   = w_zero_tok;
        w_nres     = 2'd0;
        w_again    = 1'b0;
        w_err      = 1'b0;
        w_err_code = etl_pkg::E_UNEXP;

        unique case (r_mode)
            M_AMP, M_BAR, M_EQ, M_EXCL: begin
                if ((r_mode == M_AMP && i_ch == "&") || (r_mode == M_BAR && i_ch == "|") ||
                    ((r_mode == M_EQ || r_mode == M_EXCL) && i_ch == "=")) begin
                    unique case (r_mode)
                        M_AMP:   w_res[0] = etl_pkg::mk_tok(etl_pkg::K_LAND, '0, 8'd0, 8'd0, 3'd0);
                        M_BAR:   w_res[0] = etl_pkg::mk_tok(etl_pkg::K_LOR, '0, 8'd0, 8'd0, 3'd0);
                        M_EQ:    w_res[0] = etl_pkg::mk_tok(etl_pkg::K_EQEQ, '0, 8'd0, 8'd0, 3'd0);
                        default: w_res[0] = etl_pkg::mk_tok(etl_pkg::K_NE, '0, 8'd0, 8'd0, 3'd0);
                    endcase
                    n_mode = M_IDLE;
                end else begin
                    unique case (r_mode)
                        M_AMP:   w_res[0] = etl_pkg::mk_tok(etl_pkg::K_AMP, '0, 8'd0, 8'd0, 3'd0);
                        M_BAR:   w_res[0] = etl_pkg::mk_tok(etl_pkg::K_BAR, '0, 8'd0, 8'd0, 3'd0);
                        M_EQ:    w_res[0] = etl_pkg::mk_tok(etl_pkg::K_ASSIGN, '0, 8'd0, 8'd0, 3'd0);
                        default: w_res[0] = etl_pkg::mk_tok(etl_pkg::K_NOT, '0, 8'd0, 8'd0, 3'd0);
                    endcase
                    w_again = 1'b1;
                end
                w_nres = 2'd1;
            end
            M_LT, M_GT: begin
                w_nres = 2'd1;
                if (i_ch == ((r_mode == M_LT) ? 8'h3C : 8'h3E)) begin
                    w_res[0] = etl_pkg::mk_tok((r_mode == M_LT) ? etl_pkg::K_SHL : etl_pkg::K_SHR,
                                               '0, 8'd0, 8'd0, 3'd0);
                    n_mode = M_IDLE;
                end else if (i_ch == "=") begin
                    w_res[0] = etl_pkg::mk_tok((r_mode == M_LT) ? etl_pkg::K_LE : etl_pkg::K_GE,
                                               '0, 8'd0, 8'd0, 3'd0);
                    n_mode = M_IDLE;
                end else begin
                    w_res[0] = etl_pkg::mk_tok((r_mode == M_LT) ? etl_pkg::K_LT : etl_pkg::K_GT,
                                               '0, 8'd0, 8'd0, 3'd0);
                    w_again = 1'b1;
                end
            end
            M_DOLLAR, M_HASH: begin
                if (w_ok) begin
                    n_acc  = {{(VW-4){1'b0}}, w_dv};
                    n_mode = M_HEX;
                end else begin
                    w_res[0] = etl_pkg::mk_tok((r_mode == M_DOLLAR) ? etl_pkg::K_DOLLAR
                                               : etl_pkg::K_HASH, '0, 8'd0, 8'd0, 3'd0);
                    w_nres   = 2'd1;
                    w_again  = 1'b1;
                end
            end
            M_ZERO: begin
                if (i_ch == "x" || i_ch == "X") begin
                    n_mode = M_HEXS;
                end else if (i_ch == "b" || i_ch == "B") begin
                    n_mode = M_BINS;
                end else if (i_ch == "o" || i_ch == "O") begin
                    n_mode = M_OCTS;
                end else if (etl_pkg::is_dig(i_ch)) begin
                    w_err      = 1'b1;
                    w_err_code = etl_pkg::E_LZERO;
                end else if (etl_pkg::is_identch(i_ch)) begin
                    w_err      = 1'b1;
                    w_err_code = etl_pkg::E_DEC;
                end else begin
                    w_res[0] = etl_pkg::mk_tok(etl_pkg::K_NUMBER, '0, 8'd0, 8'd0, 3'd0);
                    w_nres   = 2'd1;
                    w_again  = 1'b1;
                end
            end
            M_HEXS, M_BINS, M_OCTS: begin
                if (w_ok) begin
                    n_acc  = {{(VW-4){1'b0}}, w_dv};
                    n_mode = (r_mode == M_HEXS) ? M_HEX : ((r_mode == M_BINS) ? M_BIN : M_OCT);
                end else begin
                    w_err      = 1'b1;
                    w_err_code = (r_mode == M_HEXS) ? etl_pkg::E_HEX
                               : ((r_mode == M_BINS) ? etl_pkg::E_BIN : etl_pkg::E_OCT);
                end
            end
            M_HEX, M_BIN, M_OCT, M_DEC: begin
                if (w_ok) begin
                    n_acc = w_mac;
                end else if (etl_pkg::is_identch(i_ch)) begin
                    w_err = 1'b1;
                    unique case (r_mode)
                        M_HEX:   w_err_code = etl_pkg::E_HEX;
                        M_BIN:   w_err_code = etl_pkg::E_BIN;
                        M_OCT:   w_err_code = etl_pkg::E_OCT;
                        default: w_err_code = etl_pkg::E_DEC;
                    endcase
                end else begin
                    w_res[0] = etl_pkg::mk_tok(etl_pkg::K_NUMBER, r_acc, 8'd0, 8'd0, 3'd0);
                    w_nres   = 2'd1;
                    n_acc    = '0;
                    w_again  = 1'b1;
                end
            end
            M_IDENT: begin
                if (etl_pkg::is_identch(i_ch) || i_ch == etl_pkg::CH_APOS) begin
                    if (r_cnt >= etl_pkg::MAX_IDENT_LEN) begin
                        w_err      = 1'b1;
                        w_err_code = etl_pkg::E_LONG;
                    end else begin
                        w_res[0] = etl_pkg::mk_tok(etl_pkg::K_ICHAR, '0, i_ch, 8'd0, 3'd0);
                        w_nres   = 2'd1;
                        n_cnt    = r_cnt + 8'd1;
                        if (i_ch == etl_pkg::CH_APOS) begin
                            // apostrophe closes the identifier
                            w_res[1] = etl_pkg::mk_tok(etl_pkg::K_IDENT, '0, 8'd0, n_cnt, 3'd0);
                            w_nres   = 2'd2;
                            n_cnt    = 8'd0;
                            n_mode   = M_IDLE;
                        end
                    end
                end else begin
                    w_res[0] = etl_pkg::mk_tok(etl_pkg::K_IDENT, '0, 8'd0, r_cnt, 3'd0);
                    w_nres   = 2'd1;
                    n_cnt    = 8'd0;
                    w_again  = 1'b1;
                end
            end
            M_DRAIN: begin
                if (i_ch == 8'd0) begin
                    n_mode = M_IDLE;
                end
            end
            default: begin
                w_again = 1'b1;
            end
        endcase

        // byte not consumed by a held token: handle it from idle
        if (w_again) begin
            n_mode = M_IDLE;
            unique case (i_ch)
                8'h00: begin
                    w_res[w_nres[0]] = etl_pkg::mk_tok(etl_pkg::K_END, '0, 8'd0, 8'd0, 3'd0);
                    w_nres = w_nres + 2'd1;
                end
                8'h20, 8'h09, 8'h0D, 8'h0A: begin
                end
                ",", "@", "(", ")", "[", "]", "?", ":", "+", "-", "*", "/", "%", "^", "~": begin
                    w_res[w_nres[0]] = etl_pkg::mk_tok(punct_kind(i_ch), '0, 8'd0, 8'd0, 3'd0);
                    w_nres = w_nres + 2'd1;
                end
                "&": n_mode = M_AMP;
                "|": n_mode = M_BAR;
                "=": n_mode = M_EQ;
                "!": n_mode = M_EXCL;
                "<": n_mode = M_LT;
                ">": n_mode = M_GT;
                "$": n_mode = M_DOLLAR;
                "#": n_mode = M_HASH;
                "0": begin
                    n_acc  = '0;
                    n_mode = M_ZERO;
                end
                default: begin
                    if (etl_pkg::is_dig(i_ch)) begin
                        n_acc  = {{(VW-4){1'b0}}, w_dv};
                        n_mode = M_DEC;
                    end else if (etl_pkg::is_identch(i_ch)) begin
                        n_cnt  = 8'd1;
                        w_res[w_nres[0]] = etl_pkg::mk_tok(etl_pkg::K_ICHAR, '0, i_ch, 8'd0, 3'd0);
                        w_nres = w_nres + 2'd1;
                        n_mode = M_IDENT;
                    end else begin
                        w_err      = 1'b1;
                        w_err_code = etl_pkg::E_UNEXP;
                    end
                end
            endcase
        end

        // error token, then drop bytes through the terminating zero
        if (w_err) begin
            w_res[w_nres[0]] = etl_pkg::mk_tok(etl_pkg::K_ERROR, '0, 8'd0, 8'd0, w_err_code);
            w_nres = w_nres + 2'd1;
            n_acc  = '0;
            n_cnt  = 8'd0;
            n_mode = (i_ch == 8'd0) ? M_IDLE : M_DRAIN;
        end
    end

    assign o_push = i_accept && (w_nres != 2'd0);
    assign o_rec  = {w_nres[1], w_res};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE;
            r_acc  <= '0;
            r_cnt  <= 8'd0;
        end else if (i_accept) begin
            r_mode <= n_mode;
            r_acc  <= n_acc;
            r_cnt  <= n_cnt;
        end
    end

endmodule

`default_nettype wire

// ----- design/etl_queue.sv -----
// Token record queue between the lexer front and back parts.
// Small register FIFO of etl_pkg::t_rec records. Uses etl_pkg.
`default_nettype none

module etl_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire etl_pkg::t_rec i_rec,
    input  wire logic          i_pop,
    output etl_pkg::t_rec      o_rec,
    output logic               o_full,
    output logic               o_empty
);

    localparam int QAW = etl_pkg::QAW;
    localparam int QCW = etl_pkg::QCW;

    etl_pkg::t_rec    r_mem [etl_pkg::QDEPTH];
    logic [QAW-1:0]   r_wp, r_rp;
    logic [QCW-1:0]   r_count;
    logic [QCW-1:0]   w_inc, w_dec;

    assign w_inc   = {{QAW{1'b0}}, i_push};
    assign w_dec   = {{QAW{1'b0}}, i_pop};
    assign o_full  = (r_count == QCW'(etl_pkg::QDEPTH));
    assign o_empty = (r_count == '0);
    assign o_rec   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_count <= r_count + w_inc - w_dec;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full) else $error("token queue push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty) else $error("token queue pop while empty");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_count == $past(r_count) + $past(w_inc) - $past(w_dec)))
        else $error("token queue count out of step with push and pop");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wp - r_rp) == r_count[QAW-1:0])
        else $error("token queue pointers disagree with count");

endmodule

`default_nettype wire

// ----- design/etl_back.sv -----
// Back part of the expression token lexer: splits queued records into single tokens
// and holds each in the output register until taken. Uses etl_pkg.
`default_nettype none

module etl_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_empty,
    input  wire etl_pkg::t_rec i_rec,
    output logic               o_pop,
    output logic               o_valid,
    input  wire logic          i_ready,
    output etl_pkg::t_tok      o_tok,
    output logic               o_last
);

    logic           r_valid;
    logic           r_sel;
    logic           r_last;
    etl_pkg::t_tok  r_tok;
    logic           w_load;
    logic           w_final;

    assign w_load  = (!r_valid || i_ready) && !i_empty;
    // second token of a pair, or the only token: the record is done
    assign w_final = !i_rec.two || r_sel;
    assign o_pop   = w_load && w_final;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sel   <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
            r_sel   <= !w_final;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_tok  <= i_rec.res[r_sel];
            r_last <= w_final;
        end
    end

    assign o_valid = r_valid;
    assign o_tok   = r_tok;
    assign o_last  = r_last;

endmodule

`default_nettype wire

// ----- design/expression_token_lexer.sv -----
// Top level of the expression token lexer: front scanner, token queue, output stage.
// Depends on etl_pkg, etl_front, etl_queue and etl_back.
//
// Usage:
//   Input channel (i_valid / o_ready / i_ch) carries one text byte per request; a zero
//   byte ends the expression. Output channel (o_valid / i_ready / o_* fields) carries
//   one token per request. A byte gives zero, one or two tokens; o_last marks the
//   final token caused by a byte. Operators that may take a second character, and
//   numbers and identifiers, are held until the byte after them arrives.
//   Throughput: one byte per cycle while the output keeps up; a byte that yields two
//   tokens passes them through the single output register in turn.
//   A token's record is written into the queue when the byte that completes it is
//   accepted; the token then moves from the queue into the output register.
//   The byte classifier and accumulator update are combinational before the front's
//   registers; acc * base is built from shifts, so the wide add in the front sets the clock.
//   Stalls: when i_ready is low the output holds; the four-record queue keeps the
//   front taking bytes until it fills, then o_ready drops.
//   Reset (i_rst_n low, synchronous): scanner returns to idle between tokens, the
//   accumulator and identifier count clear, the queue and output empty.
//   After an error token, bytes are dropped silently through the next zero byte.
`default_nettype none

module expression_token_lexer (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [7:0]                    i_ch,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [5:0]                         o_token_kind,
    output logic [etl_pkg::VALUE_W-1:0]        o_number_value,
    output logic [7:0]                         o_ident_char,
    output logic [7:0]                         o_ident_length,
    output logic [2:0]                         o_error_code,
    output logic                               o_last
);

    logic           w_accept;
    logic           w_push;
    logic           w_pop;
    logic           w_full;
    logic           w_empty;
    etl_pkg::t_rec  w_push_rec;
    etl_pkg::t_rec  w_head_rec;
    etl_pkg::t_tok  w_tok;

    // take a byte whenever the queue has room for its record
    assign o_ready  = !w_full;
    assign w_accept = i_valid && o_ready;

    etl_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_ch     (i_ch),
        .o_push   (w_push),
        .o_rec    (w_push_rec)
    );

    etl_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_rec    (w_push_rec),
        .i_pop    (w_pop),
        .o_rec    (w_head_rec),
        .o_full   (w_full),
        .o_empty  (w_empty)
    );

    etl_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (w_empty),
        .i_rec    (w_head_rec),
        .o_pop    (w_pop),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_tok    (w_tok),
        .o_last   (o_last)
    );

    // unpack the held token onto the field ports
    assign o_token_kind   = w_tok.kind;
    assign o_number_value = w_tok.value;
    assign o_ident_char   = w_tok.ichar;
    assign o_ident_length = w_tok.ilen;
    assign o_error_code   = w_tok.err;

endmodule

`default_nettype wire
